@@ hdl/sdas_pkg.sv @@
// Package with the shared types, codes and helper functions of the auto-switch controller.
`timescale 1ns / 1ps

package sdas_pkg;

   localparam int MAX_INPUTS = 16;
   localparam int SIG_WIDTH = 16;
   localparam int COUNT_WIDTH = 5;
   localparam int CHAN_WIDTH = 8;
   localparam int TICK_WIDTH = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT =
      (MAX_INPUTS < SIG_WIDTH) ? COUNT_WIDTH'(MAX_INPUTS) : COUNT_WIDTH'(SIG_WIDTH);

   localparam logic [TICK_WIDTH-1:0] DEBOUNCE_RESET = 16'd500;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_SIGNAL = 2'd1;
   localparam logic [1:0] OP_INPUT  = 2'd2;

   localparam logic [1:0] ACT_NONE     = 2'd0;
   localparam logic [1:0] ACT_NOTIFY   = 2'd1;
   localparam logic [1:0] ACT_RENOTIFY = 2'd2;
   localparam logic [1:0] ACT_SWITCH   = 2'd3;

   localparam logic CSR_AUTO_ENABLE    = 1'b0;
   localparam logic CSR_DEBOUNCE_TICKS = 1'b1;

   typedef struct packed {
      logic [1:0]             op;
      logic [SIG_WIDTH-1:0]   sig_bits;
      logic [COUNT_WIDTH-1:0] sig_count;
      logic [CHAN_WIDTH-1:0]  input_number;
   } req_type;

   typedef struct packed {
      logic [1:0]            action;
      logic [CHAN_WIDTH-1:0] channel;
   } rsp_type;

   typedef struct packed {
      logic                  auto_enable;
      logic [TICK_WIDTH-1:0] debounce_ticks;
   } cfg_type;

   function automatic logic [SIG_WIDTH-1:0] low_mask(input logic [COUNT_WIDTH-1:0] n);
      logic [SIG_WIDTH-1:0] mask;
      if (n >= COUNT_WIDTH'(SIG_WIDTH)) begin
         mask = '1;
      end else begin
         mask = (SIG_WIDTH'(1) << n[3:0]) - SIG_WIDTH'(1);
      end
      return mask;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] clamp_count(input logic [COUNT_WIDTH-1:0] n);
      logic [COUNT_WIDTH-1:0] r;
      r = (n > COUNT_LIMIT) ? COUNT_LIMIT : n;
      return r;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] highest_set(input logic [SIG_WIDTH-1:0] v);
      logic [COUNT_WIDTH-1:0] pos;
      pos = '0;
      for (int i = 0; i < SIG_WIDTH; i++) begin
         if (v[i]) begin
            pos = COUNT_WIDTH'(i + 1);
         end
      end
      return pos;
   endfunction

endpackage

@@ hdl/signal_debounce_auto_switch.sv @@
// Top level of the auto-switch controller: channel registers, settings and core.
//
//   Channel | Direction | Handshake          | Payload
//   req_    | in        | req_valid/req_stall | req_type: op, sig_bits, sig_count, input_number
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_type: action, channel
//   csr_    | in        | csr_write           | csr_index, csr_wdata
//
// Every transfer on req_ yields exactly one transfer on rsp_, through the input register and then the output register.
// One item is taken per cycle while req_stall is low; the input register feeds the core, whose result lands in the
// output register in the same step as the state update.
// Synchronous reset clears valid flags, settings and core state; no clearing pass is needed.
// A stall on rsp_ holds the output register and backs up into req_stall only when both
// registers are full.
`timescale 1ns / 1ps

module signal_debounce_auto_switch (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sdas_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sdas_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);
   import sdas_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   cfg_type cfg_ff, cfg_in;
   logic    accept;
   logic    advance;
   rsp_type result;

   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_AUTO_ENABLE:    cfg_in.auto_enable = csr_wdata[0];
            CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   sdas_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (in_data_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff.auto_enable    <= 1'b0;
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_none_has_no_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.action == ACT_NONE)) |-> (rsp_data.channel == '0))
      else $error("Result with no action carries a channel.");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("Processed item did not reach the output register.");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("Input stalled while a register was free.");

   a_notify_echoes_input: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_data_ff.op == OP_INPUT) && (in_data_ff.input_number != '0)) |=>
      ((rsp_data.action == ACT_NOTIFY) && (rsp_data.channel == $past(in_data_ff.input_number))))
      else $error("Input report was not echoed.");
`endif

endmodule

@@ hdl/sdas_core.sv @@
// Debounce state and the combinational decision logic for one item.
`timescale 1ns / 1ps

module sdas_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_fire,
   input  sdas_pkg::req_type item,
   input  sdas_pkg::cfg_type cfg,
   output sdas_pkg::rsp_type result
);
   import sdas_pkg::*;

   logic [SIG_WIDTH-1:0]   pending_bits_ff, pending_bits_in;
   logic [SIG_WIDTH-1:0]   stable_bits_ff, stable_bits_in;
   logic [COUNT_WIDTH-1:0] pending_count_ff, pending_count_in;
   logic [TICK_WIDTH-1:0]  hold_ticks_ff, hold_ticks_in;
   logic                   report_seen_ff, report_seen_in;
   logic                   signal_lost_ff, signal_lost_in;
   logic [CHAN_WIDTH-1:0]  selected_input_ff, selected_input_in;

   logic [COUNT_WIDTH-1:0] rep_count;
   logic [SIG_WIDTH-1:0]   rep_mask;
   logic [SIG_WIDTH-1:0]   rep_bits;
   logic                   rep_changed;
   logic [SIG_WIDTH-1:0]   pend_mask;
   logic [TICK_WIDTH-1:0]  hold_next;
   logic                   settle;
   logic [SIG_WIDTH-1:0]   stable_next;
   logic [COUNT_WIDTH-1:0] top;
   logic [CHAN_WIDTH-1:0]  top_chan;

   always_comb begin
      rep_count   = clamp_count(item.sig_count);
      rep_mask    = low_mask(rep_count);
      rep_bits    = item.sig_bits & rep_mask;
      rep_changed = (rep_count != pending_count_ff) ||
                    (rep_bits != (pending_bits_ff & rep_mask));
      pend_mask   = low_mask(pending_count_ff);
      hold_next   = (hold_ticks_ff == '1) ? hold_ticks_ff : hold_ticks_ff + TICK_WIDTH'(1);
      settle      = cfg.auto_enable && (pending_count_ff != '0) && report_seen_ff &&
                    (((pending_bits_ff ^ stable_bits_ff) & pend_mask) != '0) &&
                    (hold_next >= cfg.debounce_ticks);
      stable_next = (stable_bits_ff & ~pend_mask) | (pending_bits_ff & pend_mask);
      top         = highest_set(stable_next & pend_mask);
      top_chan    = {{(CHAN_WIDTH-COUNT_WIDTH){1'b0}}, top};

      pending_bits_in   = pending_bits_ff;
      stable_bits_in    = stable_bits_ff;
      pending_count_in  = pending_count_ff;
      hold_ticks_in     = hold_ticks_ff;
      report_seen_in    = report_seen_ff;
      signal_lost_in    = signal_lost_ff;
      selected_input_in = selected_input_ff;
      result.action     = ACT_NONE;
      result.channel    = '0;

      case (item.op)
         OP_SIGNAL: begin
            if ((item.sig_count != '0) && rep_changed) begin
               pending_bits_in  = rep_bits;
               pending_count_in = rep_count;
               hold_ticks_in    = '0;
               report_seen_in   = 1'b1;
            end
         end
         OP_INPUT: begin
            if (item.input_number != '0) begin
               selected_input_in = item.input_number;
               result.action     = ACT_NOTIFY;
               result.channel    = item.input_number;
            end
         end
         OP_TICK: begin
            hold_ticks_in = hold_next;
            if (settle) begin
               stable_bits_in = stable_next;
               if (top == '0) begin
                  signal_lost_in = 1'b1;
               end else if (top_chan == selected_input_ff) begin
                  if (signal_lost_ff) begin
                     signal_lost_in = 1'b0;
                     result.action  = ACT_RENOTIFY;
                     result.channel = top_chan;
                  end
               end else begin
                  signal_lost_in = 1'b0;
                  result.action  = ACT_SWITCH;
                  result.channel = top_chan;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff   <= '0;
         stable_bits_ff    <= '0;
         pending_count_ff  <= '0;
         hold_ticks_ff     <= '0;
         report_seen_ff    <= 1'b0;
         signal_lost_ff    <= 1'b0;
         selected_input_ff <= '0;
      end else if (item_fire) begin
         pending_bits_ff   <= pending_bits_in;
         stable_bits_ff    <= stable_bits_in;
         pending_count_ff  <= pending_count_in;
         hold_ticks_ff     <= hold_ticks_in;
         report_seen_ff    <= report_seen_in;
         signal_lost_ff    <= signal_lost_in;
         selected_input_ff <= selected_input_in;
      end
   end

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the auto-switch controller: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module testbench;
   import sdas_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_PERCENT = 15;
   localparam int LONG_HOLD_CYCLES = 60;

   logic clock = 1'b0;
   logic reset;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write;
   logic csr_index;
   logic [15:0] csr_wdata;

   signal_debounce_auto_switch dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int error_count = 0;
   logic quiet;
   int hold_asked;
   int hold_served = 0;
   int hold_left = 0;
   logic [7:0] last_pick = 8'd0;

   // Shadow copy of the controller state and settings.
   logic cfg_enable = 1'b0;
   logic [15:0] cfg_debounce = DEBOUNCE_RESET;
   logic [15:0] pend_bits = '0;
   logic [15:0] stable_bits = '0;
   logic [4:0] pend_count = '0;
   logic [15:0] hold_ticks = '0;
   logic report_seen = 1'b0;
   logic lost = 1'b0;
   logic [7:0] selected = '0;

   function automatic rsp_type next_action(req_type r);
      logic [4:0] n;
      logic [15:0] m;
      logic [15:0] nb;
      logic [4:0] top;
      rsp_type res;
      res.action = ACT_NONE;
      res.channel = '0;
      case (r.op)
         OP_SIGNAL: begin
            if (r.sig_count != 0) begin
               n = (r.sig_count > 5'd16) ? 5'd16 : r.sig_count;
               m = 16'((32'd1 << n) - 32'd1);
               nb = r.sig_bits & m;
               if (n != pend_count || nb != (pend_bits & m)) begin
                  pend_bits = nb;
                  pend_count = n;
                  hold_ticks = '0;
                  report_seen = 1'b1;
               end
            end
         end
         OP_INPUT: begin
            if (r.input_number != 0) begin
               selected = r.input_number;
               res.action = ACT_NOTIFY;
               res.channel = r.input_number;
            end
         end
         OP_TICK: begin
            if (hold_ticks != 16'hFFFF) hold_ticks = hold_ticks + 16'd1;
            if (cfg_enable && pend_count != 0 && report_seen) begin
               m = 16'((32'd1 << pend_count) - 32'd1);
               if (((pend_bits ^ stable_bits) & m) != 0 && hold_ticks >= cfg_debounce) begin
                  stable_bits = (stable_bits & ~m) | (pend_bits & m);
                  top = '0;
                  for (int i = 0; i < 16; i++) begin
                     if (stable_bits[i] && m[i]) top = 5'(i + 1);
                  end
                  if (top == 0) begin
                     lost = 1'b1;
                  end else if (8'(top) == selected) begin
                     if (lost) begin
                        lost = 1'b0;
                        res.action = ACT_RENOTIFY;
                        res.channel = 8'(top);
                     end
                  end else begin
                     lost = 1'b0;
                     res.action = ACT_SWITCH;
                     res.channel = 8'(top);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.insert(expected_rsps.size(), next_action(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual %p", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.action != want.action) begin
                  $display("%0t: action mismatch, expected %0d, actual %0d",
                           $time, want.action, rsp_data.action);
                  error_count++;
               end
               if (rsp_data.channel != want.channel) begin
                  $display("%0t: channel mismatch, expected %0d, actual %0d",
                           $time, want.channel, rsp_data.channel);
                  error_count++;
               end
            end
         end
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   task automatic add_item(logic [1:0] op, logic [15:0] bits, logic [4:0] cnt, logic [7:0] num);
      req_type r;
      r.op = op;
      r.sig_bits = bits;
      r.sig_count = cnt;
      r.input_number = num;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_AUTO_ENABLE) cfg_enable = value[0];
      else cfg_debounce = value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [4:0] pick_count();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 5'd0;
      if (r == 1) return 5'($urandom_range(31, 17));
      if (r == 2) return 5'd16;
      return 5'($urandom_range(16, 1));
   endfunction

   function automatic logic [15:0] pick_bits();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      if (r <= 3) begin
         if (last_pick >= 1 && last_pick <= 16) return 16'(1) << (last_pick - 1);
         return 16'(1) << $urandom_range(15);
      end
      return 16'($urandom);
   endfunction

   task automatic random_burst(int count, int max_ticks);
      int made;
      int k;
      int ticks;
      logic [7:0] num;
      made = 0;
      @(negedge clock);
      while (made < count) begin
         k = $urandom_range(99);
         if (k < 55) begin
            add_item(OP_SIGNAL, pick_bits(), pick_count(), 8'($urandom));
            ticks = $urandom_range(max_ticks);
            repeat (ticks) add_item(OP_TICK, 16'($urandom), 5'($urandom), 8'($urandom));
            made += 1 + ticks;
         end else if (k < 75) begin
            k = $urandom_range(9);
            if (k == 0) num = 8'd0;
            else if (k == 1) num = 8'($urandom_range(255));
            else num = 8'($urandom_range(16, 1));
            if (num != 0) last_pick = num;
            add_item(OP_INPUT, 16'($urandom), 5'($urandom), num);
            made++;
         end else if (k < 85) begin
            add_item(OP_TICK, 16'($urandom), 5'($urandom), 8'($urandom));
            made++;
         end else if (k < 95) begin
            add_item(OP_SIGNAL, 16'($urandom), 5'($urandom), 8'($urandom));
            made++;
         end else begin
            add_item(OP_UNUSED, 16'($urandom), 5'($urandom), 8'($urandom));
            made++;
         end
      end
      wait_drained();
   endtask

   initial begin
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= 1'b0;
      csr_wdata <= '0;
      quiet <= 1'b0;
      hold_asked <= 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Settings straight out of reset: switching is off.
      @(negedge clock);
      add_item(OP_UNUSED, 16'hFFFF, 5'd31, 8'hFF);
      add_item(OP_INPUT, 16'hFFFF, 5'd31, 8'd0);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_SIGNAL, 16'hFFFF, 5'd0, 8'd0);
      wait_drained();

      write_csr(CSR_AUTO_ENABLE, 16'd1);
      write_csr(CSR_DEBOUNCE_TICKS, 16'd0);
      @(negedge clock);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_INPUT, 16'h0000, 5'd0, 8'd5);
      add_item(OP_SIGNAL, 16'h0010, 5'd8, 8'd0);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_SIGNAL, 16'h0010, 5'd8, 8'd0);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_SIGNAL, 16'h0000, 5'd8, 8'd0);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_SIGNAL, 16'h0010, 5'd8, 8'd0);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_SIGNAL, 16'hFFFF, 5'd31, 8'd0);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_SIGNAL, 16'hFFF8, 5'd3, 8'd0);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_SIGNAL, 16'h0001, 5'd1, 8'd0);
      add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_INPUT, 16'h0000, 5'd0, 8'd255);
      add_item(OP_INPUT, 16'h0000, 5'd0, 8'd1);
      add_item(OP_UNUSED, 16'h0000, 5'd0, 8'd0);
      wait_drained();

      random_burst(200, 3);

      // The receiver holds off for a long stretch while the sender keeps offering.
      write_csr(CSR_DEBOUNCE_TICKS, 16'd1);
      @(posedge clock);
      quiet <= 1'b1;
      hold_asked <= hold_asked + 1;
      random_burst(200, 4);
      @(posedge clock);
      quiet <= 1'b0;

      write_csr(CSR_AUTO_ENABLE, 16'd0);
      write_csr(CSR_DEBOUNCE_TICKS, 16'd2);
      random_burst(150, 5);

      write_csr(CSR_AUTO_ENABLE, 16'd1);
      write_csr(CSR_DEBOUNCE_TICKS, 16'd3);
      random_burst(200, 6);

      // Long debounce: a new vector has to hold for many ticks before the switch.
      write_csr(CSR_DEBOUNCE_TICKS, 16'd40);
      @(negedge clock);
      add_item(OP_SIGNAL, 16'h0004, 5'd4, 8'd0);
      repeat (45) add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      add_item(OP_SIGNAL, 16'h0000, 5'd4, 8'd0);
      repeat (5) add_item(OP_TICK, 16'h0000, 5'd0, 8'd0);
      wait_drained();

      write_csr(CSR_DEBOUNCE_TICKS, 16'd2);
      random_burst(200, 5);

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("signal_debounce_auto_switch test passed");
      end else begin
         $display("signal_debounce_auto_switch test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("signal_debounce_auto_switch test failed");
      $finish;
   end

endmodule
